[rtl/led_wave_crossfade_sequencer_assert.svh]
// Assertion macros shared by the LED wave crossfade sequencer modules.
`ifndef LED_WAVE_CROSSFADE_SEQUENCER_ASSERT_SVH
`define LED_WAVE_CROSSFADE_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LWCS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lwcs assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LWCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lwcs assertion failed");
`else
`define LWCS_ASSERT_IMPL(label, ante, cons)
`define LWCS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/lwcs_pkg.sv]
// Types and constants shared by the LED wave crossfade sequencer.
`timescale 1ns / 1ps
package lwcs_pkg;

  // Configuration register indexes.
  localparam logic [7:0] REG_FADE_PERIOD   = 8'd0;
  localparam logic [7:0] REG_PAUSE_PERIOD  = 8'd1;
  localparam logic [7:0] REG_FADE_STEP     = 8'd2;
  localparam logic [7:0] REG_STAGGER_LEVEL = 8'd3;

  // Configuration reset values.
  localparam logic [15:0] FADE_PERIOD_RST   = 16'd5;
  localparam logic [15:0] PAUSE_PERIOD_RST  = 16'd450;
  localparam logic [7:0]  FADE_STEP_RST     = 8'd3;
  localparam logic [7:0]  STAGGER_LEVEL_RST = 8'd127;

  // Level and position constants.
  localparam logic [7:0] LEVEL_MAX     = 8'd255;
  localparam logic [4:0] POS_MINUS_ONE = 5'd31;

  typedef struct packed {
    logic [15:0] fade_period;
    logic [15:0] pause_period;
    logic [7:0]  fade_step;
    logic [7:0]  stagger_level;
  } cfg_t;

  // One PWM level write.
  typedef struct packed {
    logic [3:0] led_index;
    logic [7:0] level;
    logic       last_write;
  } res_t;

  // Writes caused by one accepted item, slot w0 first.
  typedef struct packed {
    logic [1:0] n;
    res_t       w0;
    res_t       w1;
  } step_out_t;

endpackage

[rtl/lwcs_in_if.sv]
// Input channel carrying the millisecond time of each item.
`timescale 1ns / 1ps
interface lwcs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink (input valid, input now_ms, output ready);
endinterface

[rtl/lwcs_out_if.sv]
// Result channel carrying PWM level writes.
`timescale 1ns / 1ps
interface lwcs_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] led_index;
  logic [7:0] level;
  logic       last_write;

  modport source (output valid, output led_index, output level, output last_write,
                  input ready);
  modport sink (input valid, input led_index, input level, input last_write,
                output ready);
endinterface

[rtl/lwcs_cfg_if.sv]
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
interface lwcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/lwcs_cfg_regs.sv]
// Configuration registers of the sequencer.
`timescale 1ns / 1ps
module lwcs_cfg_regs import lwcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [7:0]  wr_index,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index; unknown indexes leave everything unchanged.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_FADE_PERIOD:   cfg_nxt.fade_period   = wr_data;
        REG_PAUSE_PERIOD:  cfg_nxt.pause_period  = wr_data;
        REG_FADE_STEP:     cfg_nxt.fade_step     = wr_data[7:0];
        REG_STAGGER_LEVEL: cfg_nxt.stagger_level = wr_data[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fade_period   <= FADE_PERIOD_RST;
      cfg_r.pause_period  <= PAUSE_PERIOD_RST;
      cfg_r.fade_step     <= FADE_STEP_RST;
      cfg_r.stagger_level <= STAGGER_LEVEL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/lwcs_step.sv]
// Sequencer state and the combinational step that updates it per item.
`timescale 1ns / 1ps
`include "led_wave_crossfade_sequencer_assert.svh"
module lwcs_step import lwcs_pkg::*; #(
  parameter int CHAIN_LENGTH = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [31:0] now_ms,
  input  cfg_t        cfg,
  output step_out_t   step
);

  localparam logic [4:0] CHAIN_LEN  = 5'(CHAIN_LENGTH);
  localparam logic [4:0] CHAIN_LAST = 5'(CHAIN_LENGTH - 1);
  localparam logic [4:0] CHAIN_PEN  = 5'(CHAIN_LENGTH - 2);
  localparam logic [5:0] CHAIN_LEN6 = 6'(CHAIN_LENGTH);

  function automatic logic [7:0] sat_up(input logic [7:0] v, input logic [7:0] s);
    logic [8:0] sum;
    sum = {1'b0, v} + {1'b0, s};
    return sum[8] ? LEVEL_MAX : sum[7:0];
  endfunction

  function automatic logic [7:0] sat_down(input logic [7:0] v, input logic [7:0] s);
    return (v > s) ? (v - s) : 8'd0;
  endfunction

  logic [31:0] last_step_time_r, last_step_time_nxt;
  logic [31:0] pause_start_r, pause_start_nxt;
  logic [4:0]  lead_pos_r, lead_pos_nxt;
  logic [7:0]  lead_lvl_r, lead_lvl_nxt;
  logic        rising_r, rising_nxt;
  logic        forward_r, forward_nxt;
  logic        pausing_r, pausing_nxt;
  logic        ending_r, ending_nxt;
  logic [4:0]  fe_pos_r, fe_pos_nxt;
  logic [4:0]  se_pos_r, se_pos_nxt;
  logic [7:0]  fe_lvl_r, fe_lvl_nxt;
  logic [7:0]  se_lvl_r, se_lvl_nxt;

  logic [31:0] step_elapsed;
  logic [31:0] pause_elapsed;
  logic        step_due;
  logic        pause_over;

  // Lead LED rise, shared by both passes, and the per-pass position helpers.
  logic [7:0]  rise_lvl;
  logic [7:0]  cross_lvl;
  logic        rise_full;
  logic [4:0]  fwd_pos_inc;
  logic [5:0]  bwd_tail_end;

  // Staggered end fade, shared by both passes.
  logic [7:0]  ef_first;
  logic [7:0]  ef_second;
  logic        ef_first_wr;
  logic        ef_second_wr;
  logic        ef_done;

  // Write candidates before packing into slots.
  logic        a_v, b_v;
  logic [4:0]  a_pos, b_pos;
  logic [7:0]  a_lvl, b_lvl;

  assign step_elapsed  = now_ms - last_step_time_r;
  assign pause_elapsed = now_ms - pause_start_r;
  assign step_due      = step_elapsed >= {16'd0, cfg.fade_period};
  assign pause_over    = pause_elapsed >= {16'd0, cfg.pause_period};

  assign rise_lvl     = sat_up(lead_lvl_r, cfg.fade_step);
  assign cross_lvl    = LEVEL_MAX - rise_lvl;
  assign rise_full    = rise_lvl == LEVEL_MAX;
  assign fwd_pos_inc  = lead_pos_r + 5'd1;
  assign bwd_tail_end = {1'b0, lead_pos_r} + 6'd3;

  // The second end LED starts once the first is at or below the stagger level.
  always_comb begin
    ef_first_wr  = fe_lvl_r != 8'd0;
    ef_first     = ef_first_wr ? sat_down(fe_lvl_r, cfg.fade_step) : fe_lvl_r;
    ef_second_wr = (ef_first <= cfg.stagger_level) && (se_lvl_r != 8'd0);
    ef_second    = ef_second_wr ? sat_down(se_lvl_r, cfg.fade_step) : se_lvl_r;
    ef_done      = (ef_first == 8'd0) && (ef_second == 8'd0);
  end

  // Next state and write candidates for one accepted item.
  always_comb begin
    last_step_time_nxt = last_step_time_r;
    pause_start_nxt    = pause_start_r;
    lead_pos_nxt       = lead_pos_r;
    lead_lvl_nxt       = lead_lvl_r;
    rising_nxt         = rising_r;
    forward_nxt        = forward_r;
    pausing_nxt        = pausing_r;
    ending_nxt         = ending_r;
    fe_pos_nxt         = fe_pos_r;
    se_pos_nxt         = se_pos_r;
    fe_lvl_nxt         = fe_lvl_r;
    se_lvl_nxt         = se_lvl_r;
    a_v   = 1'b0;
    a_pos = lead_pos_r;
    a_lvl = rise_lvl;
    b_v   = 1'b0;
    b_pos = lead_pos_r;
    b_lvl = cross_lvl;

    if (pausing_r) begin
      // Pause exit restarts the wave without any write.
      if (pause_over) begin
        pausing_nxt  = 1'b0;
        forward_nxt  = 1'b1;
        lead_pos_nxt = 5'd0;
        lead_lvl_nxt = 8'd0;
        rising_nxt   = 1'b1;
        ending_nxt   = 1'b0;
        fe_pos_nxt   = POS_MINUS_ONE;
        se_pos_nxt   = POS_MINUS_ONE;
      end
    end else if (step_due) begin
      last_step_time_nxt = now_ms;
      if (forward_r && !ending_r) begin
        // Forward pass: raise lead LED, crossfade the one two behind.
        if (rising_r) begin
          lead_lvl_nxt = rise_lvl;
          a_v   = 1'b1;
          b_v   = lead_pos_r >= 5'd2;
          b_pos = lead_pos_r - 5'd2;
          if (rise_full) begin
            lead_pos_nxt = fwd_pos_inc;
            lead_lvl_nxt = 8'd0;
            if (fwd_pos_inc >= CHAIN_LEN) begin
              fe_pos_nxt = CHAIN_PEN;
              se_pos_nxt = CHAIN_LAST;
              fe_lvl_nxt = LEVEL_MAX;
              se_lvl_nxt = LEVEL_MAX;
              ending_nxt = 1'b1;
            end
          end
        end
      end else if ((forward_r && ending_r) || (!forward_r && !rising_r)) begin
        // Staggered fade-out of the two end LEDs.
        fe_lvl_nxt = ef_first;
        se_lvl_nxt = ef_second;
        a_v   = ef_first_wr;
        a_pos = fe_pos_r;
        a_lvl = ef_first;
        b_v   = ef_second_wr;
        b_pos = se_pos_r;
        b_lvl = ef_second;
        if (ef_done) begin
          if (forward_r) begin
            forward_nxt  = 1'b0;
            lead_pos_nxt = CHAIN_LAST;
            lead_lvl_nxt = 8'd0;
            rising_nxt   = 1'b1;
            ending_nxt   = 1'b0;
          end else begin
            pausing_nxt     = 1'b1;
            pause_start_nxt = now_ms;
          end
        end
      end else begin
        // Backward pass: raise lead LED, crossfade the one two ahead.
        lead_lvl_nxt = rise_lvl;
        a_v   = 1'b1;
        b_v   = bwd_tail_end <= CHAIN_LEN6;
        b_pos = lead_pos_r + 5'd2;
        if (rise_full) begin
          lead_lvl_nxt = 8'd0;
          if (lead_pos_r == 5'd0) begin
            lead_pos_nxt = POS_MINUS_ONE;
            fe_pos_nxt   = 5'd1;
            se_pos_nxt   = 5'd0;
            fe_lvl_nxt   = LEVEL_MAX;
            se_lvl_nxt   = LEVEL_MAX;
            rising_nxt   = 1'b0;
          end else begin
            lead_pos_nxt = lead_pos_r - 5'd1;
          end
        end
      end
    end
  end

  // Pack candidates into output slots; the final write carries last_write.
  always_comb begin
    step.n             = accept ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
    step.w0.led_index  = a_v ? a_pos[3:0] : b_pos[3:0];
    step.w0.level      = a_v ? a_lvl : b_lvl;
    step.w0.last_write = !(a_v && b_v);
    step.w1.led_index  = b_pos[3:0];
    step.w1.level      = b_lvl;
    step.w1.last_write = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_step_time_r <= 32'd0;
      pause_start_r    <= 32'd0;
      lead_pos_r       <= 5'd0;
      lead_lvl_r       <= 8'd0;
      rising_r         <= 1'b1;
      forward_r        <= 1'b1;
      pausing_r        <= 1'b0;
      ending_r         <= 1'b0;
      fe_pos_r         <= POS_MINUS_ONE;
      se_pos_r         <= POS_MINUS_ONE;
      fe_lvl_r         <= 8'd0;
      se_lvl_r         <= 8'd0;
    end else if (accept) begin
      last_step_time_r <= last_step_time_nxt;
      pause_start_r    <= pause_start_nxt;
      lead_pos_r       <= lead_pos_nxt;
      lead_lvl_r       <= lead_lvl_nxt;
      rising_r         <= rising_nxt;
      forward_r        <= forward_nxt;
      pausing_r        <= pausing_nxt;
      ending_r         <= ending_nxt;
      fe_pos_r         <= fe_pos_nxt;
      se_pos_r         <= se_pos_nxt;
      fe_lvl_r         <= fe_lvl_nxt;
      se_lvl_r         <= se_lvl_nxt;
    end
  end

  // A paused sequencer never writes.
  `LWCS_ASSERT_IMPL(a_pause_silent, accept && pausing_r, step.n == 2'd0)
  // The ending flag is only set during the forward pass.
  `LWCS_ASSERT_IMPL(a_ending_forward, ending_r, forward_r)
  // The rise phase only ends on the backward pass.
  `LWCS_ASSERT_IMPL(a_fall_backward, !rising_r, !forward_r)

endmodule

[rtl/lwcs_res_queue.sv]
// Four-entry shifting queue that holds result items until they are taken.
`timescale 1ns / 1ps
`include "led_wave_crossfade_sequencer_assert.svh"
module lwcs_res_queue import lwcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  step_out_t push,
  input  logic      pop,
  output res_t      head,
  output logic      head_valid,
  output logic      room
);

  localparam int DEPTH = 4;
  localparam int CW    = $clog2(DEPTH + 1);

  res_t          entry_r [DEPTH];
  res_t          entry_nxt [DEPTH];
  res_t          shifted [DEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] base;

  // Drop the head on a pop, then append new writes behind what remains.
  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      shifted[i] = pop ? entry_r[i + 1] : entry_r[i];
    end
    shifted[DEPTH - 1] = entry_r[DEPTH - 1];
    base    = cnt_r - CW'(pop);
    cnt_nxt = base + CW'(push.n);
    for (int i = 0; i < DEPTH; i++) begin
      if (CW'(i) == base && push.n != 2'd0) begin
        entry_nxt[i] = push.w0;
      end else if (CW'(i) == base + CW'(1) && push.n == 2'd2) begin
        entry_nxt[i] = push.w1;
      end else begin
        entry_nxt[i] = shifted[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_r[i] <= entry_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head       = entry_r[0];
  assign head_valid = cnt_r != '0;
  assign room       = cnt_r <= CW'(DEPTH - 2);

  // New writes only arrive while two free entries remain.
  `LWCS_ASSERT_IMPL(a_no_overflow, push.n != 2'd0, cnt_r <= CW'(DEPTH - 2))
  // Without a pop, nothing leaves the queue.
  `LWCS_ASSERT_NEXT(a_hold_without_pop, !pop, cnt_r >= $past(cnt_r))

endmodule

[rtl/led_wave_crossfade_sequencer.sv]
// An accepted item's writes are registered into the result queue and leave from its head.
// Items are accepted one per cycle while each causes at most one write and out_chan.ready
// stays high; the result channel drains one write per cycle while out_chan.ready is high.
// The four-entry result queue drops in_chan.ready while it holds more than two writes.
// The step itself is one combinational update between the state and the result queue.
// Reset (rst_n low, synchronous) restores register defaults and the start of the wave.
`timescale 1ns / 1ps
module led_wave_crossfade_sequencer import lwcs_pkg::*; #(
  parameter int CHAIN_LENGTH = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  lwcs_in_if.sink    in_chan,
  lwcs_out_if.source out_chan,
  lwcs_cfg_if.sink   cfg_chan
);

  cfg_t      cfg;
  step_out_t step;
  res_t      head;
  logic      head_valid;
  logic      room;
  logic      in_accept;
  logic      out_take;

  // Handshakes.
  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = room;
  assign in_accept      = in_chan.valid && room;
  assign out_take       = head_valid && out_chan.ready;

  lwcs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_chan.valid),
    .wr_index (cfg_chan.index),
    .wr_data  (cfg_chan.data),
    .cfg      (cfg)
  );

  lwcs_step #(
    .CHAIN_LENGTH (CHAIN_LENGTH)
  ) u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .now_ms (in_chan.now_ms),
    .cfg    (cfg),
    .step   (step)
  );

  lwcs_res_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step),
    .pop        (out_take),
    .head       (head),
    .head_valid (head_valid),
    .room       (room)
  );

  // Result channel driven from the queue head.
  assign out_chan.valid      = head_valid;
  assign out_chan.led_index  = head.led_index;
  assign out_chan.level      = head.level;
  assign out_chan.last_write = head.last_write;

endmodule

[tb/led_wave_crossfade_sequencer_test.sv]
// Self-checking testbench for the LED wave crossfade sequencer.
`timescale 1ns / 1ps
module led_wave_crossfade_sequencer_test import lwcs_pkg::*;;

  localparam int CHAIN_LEN = 6;
  // Cycles to hold off after the last write before touching the registers.
  localparam int LATENCY_HOLD = 4;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;

  logic clk = 1'b0;
  logic rst_n;

  lwcs_in_if  in_chan();
  lwcs_out_if out_chan();
  lwcs_cfg_if cfg_chan();

  led_wave_crossfade_sequencer #(.CHAIN_LENGTH(CHAIN_LEN)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #5 clk = ~clk;

  // Predicted sequencer state and register copy.
  cfg_t       model_cfg;
  logic [31:0] tick_ref;
  logic [31:0] pause_t0;
  logic [4:0]  lead_pos;
  logic [7:0]  lead_lvl;
  bit          rising;
  bit          forward;
  bit          dark;
  bit          tail_fade;
  logic [4:0]  end_a_pos;
  logic [4:0]  end_b_pos;
  logic [7:0]  end_a_lvl;
  logic [7:0]  end_b_lvl;

  // Level writes of the item being predicted, and those still awaited.
  res_t burst [2];
  int   burst_n;
  res_t pending_writes [$];

  int mismatches = 0;
  int items_sent = 0;
  int writes_checked = 0;
  int reg_writes = 0;
  int waves_done = 0;
  bit idle_enable = 1'b1;
  int stall_left = 0;
  cfg_t live_cfg;
  logic [31:0] clock_ms;

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void reset_model();
    model_cfg = '{fade_period: FADE_PERIOD_RST, pause_period: PAUSE_PERIOD_RST,
                  fade_step: FADE_STEP_RST, stagger_level: STAGGER_LEVEL_RST};
    tick_ref = '0;
    pause_t0 = '0;
    lead_pos = '0;
    lead_lvl = '0;
    rising = 1'b1;
    forward = 1'b1;
    dark = 1'b0;
    tail_fade = 1'b0;
    end_a_pos = POS_MINUS_ONE;
    end_b_pos = POS_MINUS_ONE;
    end_a_lvl = '0;
    end_b_lvl = '0;
  endfunction

  function automatic void apply_register(logic [7:0] idx, logic [15:0] data);
    case (idx)
      REG_FADE_PERIOD:   model_cfg.fade_period = data;
      REG_PAUSE_PERIOD:  model_cfg.pause_period = data;
      REG_FADE_STEP:     model_cfg.fade_step = data[7:0];
      REG_STAGGER_LEVEL: model_cfg.stagger_level = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic void push_level(logic [4:0] pos, logic [7:0] lvl);
    if (burst_n < 2) begin
      burst[burst_n] = '{led_index: pos[3:0], level: lvl, last_write: 1'b0};
      burst_n++;
    end
  endfunction

  function automatic logic [7:0] level_up(logic [7:0] v);
    logic [8:0] sum;
    sum = {1'b0, v} + {1'b0, model_cfg.fade_step};
    return (sum > 9'd255) ? LEVEL_MAX : sum[7:0];
  endfunction

  function automatic logic [7:0] level_down(logic [7:0] v);
    return (v > model_cfg.fade_step) ? v - model_cfg.fade_step : 8'd0;
  endfunction

  // Staggered fade-out of the two end LEDs; true once both are dark.
  function automatic bit fade_out_ends();
    if (end_a_lvl > 0) begin
      end_a_lvl = level_down(end_a_lvl);
      push_level(end_a_pos, end_a_lvl);
    end
    if (end_a_lvl <= model_cfg.stagger_level && end_b_lvl > 0) begin
      end_b_lvl = level_down(end_b_lvl);
      push_level(end_b_pos, end_b_lvl);
    end
    return end_a_lvl == 0 && end_b_lvl == 0;
  endfunction

  // Forward pass: raise the lead LED and crossfade the one two places behind.
  function automatic void rise_forward();
    if (!rising) return;
    lead_lvl = level_up(lead_lvl);
    push_level(lead_pos, lead_lvl);
    if (lead_pos >= 5'd2) push_level(lead_pos - 5'd2, LEVEL_MAX - lead_lvl);
    if (lead_lvl == LEVEL_MAX) begin
      lead_pos = lead_pos + 5'd1;
      lead_lvl = '0;
      if (lead_pos >= CHAIN_LEN) begin
        end_a_pos = 5'(CHAIN_LEN - 2);
        end_b_pos = 5'(CHAIN_LEN - 1);
        end_a_lvl = LEVEL_MAX;
        end_b_lvl = LEVEL_MAX;
        tail_fade = 1'b1;
      end
    end
  endfunction

  // Backward pass, ending in the fade-out of LEDs 1 and 0 and the dark pause.
  function automatic void rise_backward(logic [31:0] now);
    if (rising) begin
      lead_lvl = level_up(lead_lvl);
      push_level(lead_pos, lead_lvl);
      if (int'(lead_pos) + 3 <= CHAIN_LEN) push_level(lead_pos + 5'd2, LEVEL_MAX - lead_lvl);
      if (lead_lvl == LEVEL_MAX) begin
        lead_lvl = '0;
        if (lead_pos == 5'd0) begin
          // Stepping back past the first LED starts the fade-out.
          lead_pos = POS_MINUS_ONE;
          end_a_pos = 5'd1;
          end_b_pos = 5'd0;
          end_a_lvl = LEVEL_MAX;
          end_b_lvl = LEVEL_MAX;
          rising = 1'b0;
        end else begin
          lead_pos = lead_pos - 5'd1;
        end
      end
    end else if (fade_out_ends()) begin
      dark = 1'b1;
      pause_t0 = now;
      waves_done++;
    end
  endfunction

  // Works out the level writes that one accepted item causes.
  function automatic void wave_step(logic [31:0] now);
    logic [31:0] gap;
    burst_n = 0;
    if (dark) begin
      gap = now - pause_t0;
      // The item that ends the pause only restarts the wave.
      if (gap >= {16'd0, model_cfg.pause_period}) begin
        dark = 1'b0;
        forward = 1'b1;
        lead_pos = '0;
        lead_lvl = '0;
        rising = 1'b1;
        tail_fade = 1'b0;
        end_a_pos = POS_MINUS_ONE;
        end_b_pos = POS_MINUS_ONE;
      end
    end else begin
      gap = now - tick_ref;
      if (gap >= {16'd0, model_cfg.fade_period}) begin
        tick_ref = now;
        if (forward) begin
          if (!tail_fade) begin
            rise_forward();
          end else if (fade_out_ends()) begin
            forward = 1'b0;
            lead_pos = 5'(CHAIN_LEN - 1);
            lead_lvl = '0;
            rising = 1'b1;
            tail_fade = 1'b0;
          end
        end else begin
          rise_backward(now);
        end
      end
    end
    if (burst_n > 0) burst[burst_n - 1].last_write = 1'b1;
    for (int i = 0; i < burst_n; i++) pending_writes.push_back(burst[i]);
  endfunction

  // Compares one accepted write with the oldest prediction.
  task automatic check_write(input res_t got);
    res_t want;
    if (pending_writes.size() == 0) begin
      report_mismatch($sformatf("unexpected write LED %0d level %0d last %0b",
                                got.led_index, got.level, got.last_write));
    end else begin
      want = pending_writes.pop_front();
      writes_checked++;
      if (got.led_index !== want.led_index)
        report_mismatch($sformatf("led_index %0d, predicted %0d", got.led_index,
                                  want.led_index));
      if (got.level !== want.level)
        report_mismatch($sformatf("level %0d, predicted %0d (LED %0d)", got.level,
                                  want.level, want.led_index));
      if (got.last_write !== want.last_write)
        report_mismatch($sformatf("last_write %0b, predicted %0b (LED %0d)",
                                  got.last_write, want.last_write, want.led_index));
    end
  endtask

  // Monitor: registers, results and items seen at each rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_chan.valid && cfg_chan.ready) apply_register(cfg_chan.index, cfg_chan.data);
      if (out_chan.valid && out_chan.ready)
        check_write('{led_index: out_chan.led_index, level: out_chan.level,
                      last_write: out_chan.last_write});
      if (in_chan.valid && in_chan.ready) wave_step(in_chan.now_ms);
    end
  end

  // Result-side back-pressure in random bursts, while idling is enabled.
  always @(posedge clk) begin
    if (!idle_enable) begin
      out_chan.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_chan.ready <= ($urandom_range(0, 2) != 0);
      stall_left <= $urandom_range(0, 15);
    end
  end

  // Sends one item and, at random while idling is enabled, idles the input afterwards.
  task automatic send_time(input logic [31:0] t);
    in_chan.valid <= 1'b1;
    in_chan.now_ms <= t;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Stops the input, waits for every predicted write, then lets the block settle.
  task automatic go_idle();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
    repeat (LATENCY_HOLD) @(posedge clk);
  endtask

  // One register write; valid stays high so that writes can follow back to back.
  task automatic write_register(input logic [7:0] idx, input logic [15:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= value;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    reg_writes++;
  endtask

  task automatic load_registers(input logic [15:0] fp, input logic [15:0] pp,
                                input logic [15:0] fs, input logic [15:0] sl);
    write_register(REG_FADE_PERIOD, fp);
    write_register(REG_PAUSE_PERIOD, pp);
    write_register(REG_FADE_STEP, fs);
    write_register(REG_STAGGER_LEVEL, sl);
    cfg_chan.valid <= 1'b0;
    live_cfg = '{fade_period: fp, pause_period: pp, fade_step: fs[7:0],
                 stagger_level: sl[7:0]};
  endtask

  // Reset values: steps only once the fade period has passed, with time wrap.
  task automatic test_reset_defaults();
    send_time(32'h0000_0000);
    send_time(32'h0000_0004);
    send_time(32'h0000_0005);
    send_time(32'hFFFF_FFFF);
    send_time(32'h0000_0003);
    send_time(32'h8000_0000);
  endtask

  // Zero fade and pause periods with the largest step: a whole wave, one step per item.
  task automatic test_extreme_registers();
    go_idle();
    // Unknown indexes must leave every register alone.
    write_register(8'd4, 16'h1234);
    write_register(8'hFF, 16'hFFFF);
    // Upper data bits of the 8-bit registers are dropped.
    load_registers(16'd0, 16'd0, 16'hFFFF, 16'hFF00);
    for (int n = 0; n < 16; n++) send_time(32'h5A5A_A5A5);
  endtask

  // A zero fade step keeps the wave in place but repeats its writes.
  task automatic test_zero_step();
    go_idle();
    load_registers(16'd1, 16'd450, 16'h0000, 16'd255);
    send_time(32'h0000_0100);
    send_time(32'h0000_0101);
    send_time(32'h0000_0103);
  endtask

  // Mostly well-paced time samples, with short, paused and wild jumps mixed in.
  task automatic test_random_waves();
    int unsigned fp;
    int unsigned pp;
    int unsigned pick;
    logic [31:0] delta;
    clock_ms = $urandom();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == RANDOM_PHASES - 1) idle_enable = 1'b0;
      go_idle();
      case (phase)
        0: load_registers(16'hFFFF, 16'hFFFF, 16'd255, 16'd255);
        1: load_registers(16'd1, 16'd0, 16'd1, 16'd0);
        default: load_registers(16'($urandom_range(1, 20)), 16'($urandom_range(0, 80)),
                                16'($urandom_range(32, 255)), 16'($urandom_range(0, 255)));
      endcase
      fp = live_cfg.fade_period;
      pp = live_cfg.pause_period;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Once, hold the sender until every predicted write has drained.
        if (phase == 3 && n == ITEMS_PER_PHASE / 2) go_idle();
        pick = $urandom_range(0, 99);
        if (pick < 65) delta = fp + $urandom_range(0, 2);
        else if (pick < 85) delta = $urandom_range(0, fp);
        else if (pick < 95) delta = $urandom_range(0, pp + 8);
        else delta = $urandom();
        clock_ms = clock_ms + delta;
        send_time(clock_ms);
      end
    end
  endtask

  // Watchdog: ends the run when no handshake happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // Test sequence.
  initial begin
    in_chan.valid = 1'b0;
    in_chan.now_ms = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = '0;
    cfg_chan.data = '0;
    rst_n = 1'b0;
    reset_model();
    live_cfg = model_cfg;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_extreme_registers();
    test_zero_step();
    test_random_waves();
    go_idle();
    repeat (8) @(posedge clk);

    $display("Covered %0d items, %0d level writes and %0d register writes.",
             items_sent, writes_checked, reg_writes);
    $display("%0d waves ran through to the dark pause.", waves_done);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/lwcs_pkg.sv
rtl/lwcs_in_if.sv
rtl/lwcs_out_if.sv
rtl/lwcs_cfg_if.sv
rtl/lwcs_cfg_regs.sv
rtl/lwcs_step.sv
rtl/lwcs_res_queue.sv
rtl/led_wave_crossfade_sequencer.sv
tb/led_wave_crossfade_sequencer_test.sv
